>>> design/lru_compacting_image_cache_macros.svh
// assertion macros for the lru compacting image cache
// used by the top level only, needs nothing else
`ifndef LRU_COMPACTING_IMAGE_CACHE_MACROS_SVH
`define LRU_COMPACTING_IMAGE_CACHE_MACROS_SVH

// same-cycle implication
`define LRUCC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrucc assertion failed");

// next-cycle implication
`define LRUCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrucc assertion failed");

`endif

>>> design/lrucc_pkg.sv
// shared types, constants and helpers for the lru compacting image cache
// no dependencies
package lrucc_pkg;

   localparam int MAX_ENTRIES       = 256;
   localparam int IDX_W             = $clog2(MAX_ENTRIES);
   localparam int CNT_W             = IDX_W + 1;
   localparam int HEADER_BYTES      = 16;
   localparam int FORCE_LIMIT_BYTES = 96 * 1024;
   localparam int MIN_STORE_BYTES   = 4096;
   localparam int MAX_STORE_BYTES   = 16777216;
   localparam int BYTES_W           = 25;
   localparam int ROUND_MASK        = 31;

   typedef enum logic [2:0] {
      ST_HIT       = 3'd0,
      ST_INSERTED  = 3'd1,
      ST_NO_CACHE  = 3'd2,
      ST_TOO_SMALL = 3'd3,
      ST_TOO_LARGE = 3'd4,
      ST_NO_SPACE  = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0]  request_index;
      logic [23:0] payload_size;
      logic        is_buffered;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [23:0] entry_offset;
      logic [8:0]  evicted_count;
      logic [24:0] free_after;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  image;
      logic [23:0] payload;
      logic [31:0] stamp;
      logic        protect;
   } entry_type;

   typedef struct packed {
      logic rotate;
      logic shift;
      logic write;
   } cell_ctl_type;

   // payload rounded up to a multiple of 32 bytes plus the header
   function automatic logic [BYTES_W-1:0] footprint(input logic [23:0] payload);
      logic [BYTES_W-1:0] rounded;
      rounded = ({1'b0, payload} + BYTES_W'(ROUND_MASK)) & ~BYTES_W'(ROUND_MASK);
      return rounded + BYTES_W'(HEADER_BYTES);
   endfunction

endpackage

>>> design/lrucc_cell.sv
// one table slot of the entry chain
// depends on lrucc_pkg
module lrucc_cell
   import lrucc_pkg::*;
(
   input  logic               clock,
   input  logic [IDX_W-1:0]   my_index,
   input  cell_ctl_type       ctl,
   input  logic [IDX_W-1:0]   victim,
   input  logic [CNT_W-1:0]   count,
   input  entry_type          nbr_in,
   input  entry_type          wr_in,
   output entry_type          ent_out
);

   entry_type ent_ff;

   always_ff @(posedge clock) begin
      if (ctl.rotate) begin
         ent_ff <= nbr_in;
      end else if (ctl.shift && (my_index >= victim)) begin
         // close the gap left by the victim
         ent_ff <= nbr_in;
      end else if (ctl.write && ({1'b0, my_index} == count)) begin
         ent_ff <= wr_in;
      end
   end

   assign ent_out = ent_ff;

endmodule

>>> design/lru_compacting_image_cache.sv
// top level of the lru compacting image cache: control sequencer and cell chain
// depends on lrucc_pkg, lrucc_cell and the macros header
`include "lru_compacting_image_cache_macros.svh"

// Requests are taken when start is high and busy is low; the single result
// appears for one cycle with rsp_strobe and cannot be held off. The table is a
// chain of 256 cells that rotates one place per cycle past the head cell, so
// every full walk (hit lookup or victim search) brings each place past the head
// once. A hit answers at the end of its walk. A miss that fits without eviction
// passes the miss, room check and insert states, and each eviction adds a victim
// search, a removal and another room check. A miss that finds no room answers
// after a failed victim search; a buffered request first gets a second search
// that may also evict protected entries. With the store below 4096 bytes
// the answer follows in the next cycle. Writing csr_wdata clears the table.
module lru_compacting_image_cache
   import lrucc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  req_type             req_data,
   output logic                busy,
   output logic                rsp_strobe,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [BYTES_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_HIT, S_MISS, S_ROOM, S_VSCAN, S_DEL, S_INS
   } state_type;

   state_type              state_ff;
   req_type                req_ff;
   rsp_type                rsp_ff;
   logic                   strobe_ff;
   logic [BYTES_W-1:0]     store_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [BYTES_W-1:0]     free_ff;
   logic [MAX_ENTRIES-1:0] present_ff;
   logic [31:0]            counter_ff;
   logic [IDX_W-1:0]       k_ff;
   logic [BYTES_W-1:0]     pos_ff;
   logic                   found_ff;
   logic                   force_ff;
   logic                   pass2_ff;
   logic                   vfound_ff;
   logic [IDX_W-1:0]       victim_ff;
   logic [31:0]            vstamp_ff;
   logic [7:0]             vimg_ff;
   logic [23:0]            vpay_ff;
   logic [8:0]             evict_ff;
   logic [BYTES_W-1:0]     need_ff;

   entry_type              ent [MAX_ENTRIES];
   entry_type              head;
   entry_type              tail_in;
   entry_type              wr_entry;
   cell_ctl_type           ctl;
   logic                   in_range;
   logic                   hit_now;
   logic                   upd_now;
   logic                   elig;
   logic                   take_now;
   logic                   last_k;
   logic [BYTES_W-1:0]     req_fp;
   logic [BYTES_W-1:0]     eff_size;
   logic [BYTES_W-1:0]     masked;
   logic                   room_needed;

   assign head     = ent[0];
   assign in_range = ({1'b0, k_ff} < count_ff);
   assign last_k   = (k_ff == IDX_W'(MAX_ENTRIES - 1));
   assign hit_now  = (state_ff == S_HIT) && !found_ff && in_range &&
                     (head.image == req_ff.request_index);
   assign upd_now  = hit_now && (head.payload >= req_ff.payload_size);
   assign elig     = in_range && (force_ff || !head.protect);
   assign take_now = (state_ff == S_VSCAN) && elig &&
                     (!vfound_ff || (head.stamp < vstamp_ff));
   assign req_fp   = footprint(req_ff.payload_size);
   assign room_needed = (free_ff < need_ff) || (count_ff >= CNT_W'(MAX_ENTRIES));

   always_comb begin
      tail_in = head;
      if (upd_now) begin
         tail_in.stamp = counter_ff;
      end
   end

   assign wr_entry = '{image:   req_ff.request_index,
                       payload: req_ff.payload_size,
                       stamp:   counter_ff,
                       protect: req_ff.is_buffered};

   assign ctl.rotate = (state_ff == S_HIT) || (state_ff == S_VSCAN);
   assign ctl.shift  = (state_ff == S_DEL);
   assign ctl.write  = (state_ff == S_INS);

   // effective store size from the register value
   always_comb begin
      masked = csr_wdata & ~BYTES_W'(ROUND_MASK);
      if (masked > BYTES_W'(MAX_STORE_BYTES)) begin
         eff_size = BYTES_W'(MAX_STORE_BYTES);
      end else if (masked < BYTES_W'(MIN_STORE_BYTES)) begin
         eff_size = '0;
      end else begin
         eff_size = masked;
      end
   end

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      entry_type nbr;
      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign nbr = tail_in;
      end else begin : g_mid
         assign nbr = ent[i+1];
      end
      lrucc_cell u_cell (
         .clock    (clock),
         .my_index (IDX_W'(i)),
         .ctl      (ctl),
         .victim   (victim_ff),
         .count    (count_ff),
         .nbr_in   (nbr),
         .wr_in    (wr_entry),
         .ent_out  (ent[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         strobe_ff  <= 1'b0;
         store_ff   <= '0;
         count_ff   <= '0;
         free_ff    <= '0;
         present_ff <= '0;
         counter_ff <= '0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_data;
                  evict_ff <= '0;
                  k_ff     <= '0;
                  pos_ff   <= '0;
                  found_ff <= 1'b0;
                  if (store_ff == '0) begin
                     rsp_ff    <= '{ST_NO_CACHE, 24'd0, 9'd0, free_ff};
                     strobe_ff <= 1'b1;
                  end else if (present_ff[req_data.request_index]) begin
                     state_ff <= S_HIT;
                  end else begin
                     state_ff <= S_MISS;
                  end
               end
            end
            S_HIT: begin
               k_ff <= k_ff + 1'b1;
               if (hit_now) begin
                  found_ff <= 1'b1;
                  if (upd_now) begin
                     counter_ff <= counter_ff + 1'b1;
                     rsp_ff <= '{ST_HIT, pos_ff[23:0], 9'd0, free_ff};
                  end else begin
                     rsp_ff <= '{ST_TOO_SMALL, 24'd0, 9'd0, free_ff};
                  end
               end else if (in_range && !found_ff) begin
                  pos_ff <= pos_ff + footprint(head.payload);
               end
               if (last_k) begin
                  if (found_ff || hit_now) begin
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end else begin
                     // stale presence bit
                     present_ff[req_ff.request_index] <= 1'b0;
                     state_ff <= S_MISS;
                  end
               end
            end
            S_MISS: begin
               need_ff <= req_fp;
               if (req_fp > store_ff) begin
                  rsp_ff    <= '{ST_TOO_LARGE, 24'd0, evict_ff, free_ff};
                  strobe_ff <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  force_ff <= (store_ff < BYTES_W'(FORCE_LIMIT_BYTES));
                  pass2_ff <= 1'b0;
                  state_ff <= S_ROOM;
               end
            end
            S_ROOM: begin
               k_ff      <= '0;
               vfound_ff <= 1'b0;
               state_ff  <= room_needed ? S_VSCAN : S_INS;
            end
            S_VSCAN: begin
               k_ff <= k_ff + 1'b1;
               if (take_now) begin
                  vfound_ff <= 1'b1;
                  victim_ff <= k_ff;
                  vstamp_ff <= head.stamp;
                  vimg_ff   <= head.image;
                  vpay_ff   <= head.payload;
               end
               if (last_k) begin
                  if (vfound_ff || take_now) begin
                     state_ff <= S_DEL;
                  end else if (!force_ff && req_ff.is_buffered && !pass2_ff) begin
                     // buffered request may also evict protected entries
                     pass2_ff <= 1'b1;
                     force_ff <= 1'b1;
                     state_ff <= S_ROOM;
                  end else begin
                     rsp_ff    <= '{ST_NO_SPACE, 24'd0, evict_ff, free_ff};
                     strobe_ff <= 1'b1;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            S_DEL: begin
               count_ff            <= count_ff - 1'b1;
               free_ff             <= free_ff + footprint(vpay_ff);
               present_ff[vimg_ff] <= 1'b0;
               evict_ff            <= evict_ff + 1'b1;
               state_ff            <= S_ROOM;
            end
            S_INS: begin
               count_ff   <= count_ff + 1'b1;
               free_ff    <= free_ff - need_ff;
               counter_ff <= counter_ff + 1'b1;
               present_ff[req_ff.request_index] <= 1'b1;
               rsp_ff <= '{ST_INSERTED, 24'(store_ff - free_ff), evict_ff,
                           free_ff - need_ff};
               strobe_ff <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_we) begin
            store_ff   <= eff_size;
            count_ff   <= '0;
            free_ff    <= eff_size;
            present_ff <= '0;
         end
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   `LRUCC_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ENTRIES))
   `LRUCC_ASSERT_NOW(a_free_bound, clock, reset, 1'b1, free_ff <= store_ff)
   `LRUCC_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   `LRUCC_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_strobe)

endmodule
